>>> hdl/iva_pkg.sv
// Shared types and constants of the integer 3D vector ALU.
package iva_pkg;

   localparam int COORD_WIDTH = 64;
   localparam int FIELD_WIDTH = 64;
   localparam int OP_WIDTH    = 4;
   localparam int LANES       = 3;
   localparam int HALF_WIDTH  = (COORD_WIDTH + 1) / 2;
   localparam int HIGH_WIDTH  = COORD_WIDTH - HALF_WIDTH;

   typedef logic [COORD_WIDTH-1:0] coord_type;

   typedef enum logic [OP_WIDTH-1:0] {
      OP_ADD       = 4'd0,
      OP_SUB       = 4'd1,
      OP_SCALE     = 4'd2,
      OP_DOT       = 4'd3,
      OP_CROSS     = 4'd4,
      OP_LENSQ     = 4'd5,
      OP_ISZERO    = 4'd6,
      OP_MANHATTAN = 4'd7,
      OP_CHEBYSHEV = 4'd8,
      OP_PARALLEL  = 4'd9
   } op_type;

   typedef struct packed {
      coord_type a_self;
      coord_type b_self;
      coord_type a_next;
      coord_type b_next;
      coord_type a_prev;
      coord_type b_prev;
   } lane_opnd_type;

   typedef struct packed {
      coord_type vec;
      coord_type term;
   } lane_out_type;

endpackage

>>> hdl/integer_vec3_alu.sv
// Integer 3D vector ALU top level: input register, three lanes, merge stage.
//
// One command is taken on every clock cycle in which start is high and busy is low;
// busy is registered: reset sets it, and a clock edge without reset clears it. Each
// command gives exactly one result, shown on the rsp_ ports for a single cycle with
// rsp_valid high, in command order. The pipeline runs without stalls: input register,
// partial products, product assembly, lane result, merge and output register. Its
// depth is set by the 64-bit multiplies, which each lane forms from 32-bit partial
// products over two stages. There is no backpressure, so the receiver must capture
// every strobed result in that cycle.
module integer_vec3_alu import iva_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  logic [OP_WIDTH-1:0]    req_op,
   input  logic [FIELD_WIDTH-1:0] req_ax,
   input  logic [FIELD_WIDTH-1:0] req_ay,
   input  logic [FIELD_WIDTH-1:0] req_az,
   input  logic [FIELD_WIDTH-1:0] req_bx,
   input  logic [FIELD_WIDTH-1:0] req_by,
   input  logic [FIELD_WIDTH-1:0] req_bz,
   input  logic [FIELD_WIDTH-1:0] req_factor,
   output logic                   rsp_valid,
   output logic [FIELD_WIDTH-1:0] rsp_res_x,
   output logic [FIELD_WIDTH-1:0] rsp_res_y,
   output logic [FIELD_WIDTH-1:0] rsp_res_z,
   output logic [FIELD_WIDTH-1:0] rsp_res_scalar,
   output logic                   rsp_res_flag
);

   logic          busy_ff;
   logic          accept;
   logic          valid_s0_ff, valid_s1_ff, valid_s2_ff, valid_s3_ff, valid_s4_ff;
   op_type        op_s0_ff, op_s1_ff, op_s2_ff, op_s3_ff;
   coord_type     a_ff [LANES];
   coord_type     b_ff [LANES];
   coord_type     f_ff;
   lane_opnd_type opnd [LANES];
   lane_out_type  lane_res [LANES];

   assign accept = start && !busy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff     <= 1'b1;
         valid_s0_ff <= 1'b0;
         valid_s1_ff <= 1'b0;
         valid_s2_ff <= 1'b0;
         valid_s3_ff <= 1'b0;
         valid_s4_ff <= 1'b0;
      end else begin
         busy_ff     <= 1'b0;
         valid_s0_ff <= accept;
         valid_s1_ff <= valid_s0_ff;
         valid_s2_ff <= valid_s1_ff;
         valid_s3_ff <= valid_s2_ff;
         valid_s4_ff <= valid_s3_ff;
      end
   end

   always_ff @(posedge clock) begin
      op_s0_ff <= op_type'(req_op);
      a_ff[0]  <= req_ax[COORD_WIDTH-1:0];
      a_ff[1]  <= req_ay[COORD_WIDTH-1:0];
      a_ff[2]  <= req_az[COORD_WIDTH-1:0];
      b_ff[0]  <= req_bx[COORD_WIDTH-1:0];
      b_ff[1]  <= req_by[COORD_WIDTH-1:0];
      b_ff[2]  <= req_bz[COORD_WIDTH-1:0];
      f_ff     <= req_factor[COORD_WIDTH-1:0];
      op_s1_ff <= op_s0_ff;
      op_s2_ff <= op_s1_ff;
      op_s3_ff <= op_s2_ff;
   end

   for (genvar i = 0; i < LANES; i++) begin : g_lane
      assign opnd[i].a_self = a_ff[i];
      assign opnd[i].b_self = b_ff[i];
      assign opnd[i].a_next = a_ff[(i + 1) % LANES];
      assign opnd[i].b_next = b_ff[(i + 1) % LANES];
      assign opnd[i].a_prev = a_ff[(i + 2) % LANES];
      assign opnd[i].b_prev = b_ff[(i + 2) % LANES];

      iva_lane u_lane (
         .clock    (clock),
         .op_s0    (op_s0_ff),
         .op_s2    (op_s2_ff),
         .opnd     (opnd[i]),
         .factor   (f_ff),
         .lane_out (lane_res[i])
      );
   end

   iva_merge u_merge (
      .clock      (clock),
      .op_s3      (op_s3_ff),
      .lanes      (lane_res),
      .res_x      (rsp_res_x),
      .res_y      (rsp_res_y),
      .res_z      (rsp_res_z),
      .res_scalar (rsp_res_scalar),
      .res_flag   (rsp_res_flag)
   );

   assign busy      = busy_ff;
   assign rsp_valid = valid_s4_ff;

endmodule

>>> hdl/iva_mul.sv
// Two-stage wrapping multiplier built from half-width partial products.
module iva_mul import iva_pkg::*; (
   input  logic      clock,
   input  coord_type mul_a,
   input  coord_type mul_b,
   output coord_type prod
);

   logic [2*HALF_WIDTH-1:0] ll_in, ll_ff;
   logic [2*HIGH_WIDTH-1:0] lh_full, hl_full;
   logic [HIGH_WIDTH-1:0]   lh_in, lh_ff, hl_in, hl_ff;
   logic [HIGH_WIDTH-1:0]   mid;
   coord_type               prod_in, prod_ff;

   always_comb begin
      ll_in   = (2*HALF_WIDTH)'(mul_a[HALF_WIDTH-1:0]) * (2*HALF_WIDTH)'(mul_b[HALF_WIDTH-1:0]);
      lh_full = (2*HIGH_WIDTH)'(mul_a[HIGH_WIDTH-1:0])
                * (2*HIGH_WIDTH)'(mul_b[COORD_WIDTH-1:HALF_WIDTH]);
      hl_full = (2*HIGH_WIDTH)'(mul_a[COORD_WIDTH-1:HALF_WIDTH])
                * (2*HIGH_WIDTH)'(mul_b[HIGH_WIDTH-1:0]);
      lh_in   = lh_full[HIGH_WIDTH-1:0];
      hl_in   = hl_full[HIGH_WIDTH-1:0];
      mid     = lh_ff + hl_ff;
      prod_in = ll_ff[COORD_WIDTH-1:0] + {mid, {HALF_WIDTH{1'b0}}};
   end

   always_ff @(posedge clock) begin
      ll_ff   <= ll_in;
      lh_ff   <= lh_in;
      hl_ff   <= hl_in;
      prod_ff <= prod_in;
   end

   assign prod = prod_ff;

endmodule

>>> hdl/iva_lane.sv
// One vector lane: operand select, two multipliers, add, subtract and absolute difference.
module iva_lane import iva_pkg::*; (
   input  logic          clock,
   input  op_type        op_s0,
   input  op_type        op_s2,
   input  lane_opnd_type opnd,
   input  coord_type     factor,
   output lane_out_type  lane_out
);

   coord_type    m1_a, m1_b, m2_a, m2_b, p1, p2;
   coord_type    b_add;
   coord_type    sum_in, sum_ff, sum2_ff;
   coord_type    diff_in, diff_ff, diff2_ff;
   coord_type    abs_in, abs_ff;
   lane_out_type out_in, out_ff;

   always_comb begin
      m1_a = '0;
      m1_b = '0;
      m2_a = '0;
      m2_b = '0;
      case (op_s0) inside
         OP_SCALE: begin
            m1_a = opnd.a_self;
            m1_b = factor;
         end
         OP_DOT: begin
            m1_a = opnd.a_self;
            m1_b = opnd.b_self;
         end
         OP_LENSQ: begin
            m1_a = opnd.a_self;
            m1_b = opnd.a_self;
         end
         OP_CROSS, OP_PARALLEL: begin
            m1_a = opnd.a_next;
            m1_b = opnd.b_prev;
            m2_a = opnd.a_prev;
            m2_b = opnd.b_next;
         end
         default: begin
         end
      endcase
      b_add   = (op_s0 == OP_ISZERO) ? coord_type'(0) : opnd.b_self;
      sum_in  = opnd.a_self + b_add;
      diff_in = opnd.a_self - opnd.b_self;
      abs_in  = diff_ff[COORD_WIDTH-1] ? coord_type'(0) - diff_ff : diff_ff;
   end

   iva_mul u_mul1 (
      .clock (clock),
      .mul_a (m1_a),
      .mul_b (m1_b),
      .prod  (p1)
   );

   iva_mul u_mul2 (
      .clock (clock),
      .mul_a (m2_a),
      .mul_b (m2_b),
      .prod  (p2)
   );

   always_comb begin
      out_in = '0;
      case (op_s2) inside
         OP_ADD, OP_ISZERO:        out_in.vec  = sum2_ff;
         OP_SUB:                   out_in.vec  = diff2_ff;
         OP_SCALE:                 out_in.vec  = p1;
         OP_CROSS, OP_PARALLEL:    out_in.vec  = p1 - p2;
         OP_DOT, OP_LENSQ:         out_in.term = p1;
         OP_MANHATTAN, OP_CHEBYSHEV: out_in.term = abs_ff;
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      sum_ff   <= sum_in;
      diff_ff  <= diff_in;
      sum2_ff  <= sum_ff;
      diff2_ff <= diff_ff;
      abs_ff   <= abs_in;
      out_ff   <= out_in;
   end

   assign lane_out = out_ff;

endmodule

>>> hdl/iva_merge.sv
// Merge stage: lane sum, signed maximum, zero test and result register.
module iva_merge import iva_pkg::*; (
   input  logic                   clock,
   input  op_type                 op_s3,
   input  lane_out_type           lanes [LANES],
   output logic [FIELD_WIDTH-1:0] res_x,
   output logic [FIELD_WIDTH-1:0] res_y,
   output logic [FIELD_WIDTH-1:0] res_z,
   output logic [FIELD_WIDTH-1:0] res_scalar,
   output logic                   res_flag
);

   function automatic logic [FIELD_WIDTH-1:0] sext(input coord_type v);
      logic signed [COORD_WIDTH-1:0] s;
      s = v;
      return FIELD_WIDTH'(s);
   endfunction

   coord_type              sum3, max01, max3;
   logic                   gt10, gt20, gt21, vzero;
   logic [FIELD_WIDTH-1:0] res_x_in, res_y_in, res_z_in, res_scalar_in;
   logic [FIELD_WIDTH-1:0] res_x_ff, res_y_ff, res_z_ff, res_scalar_ff;
   logic                   res_flag_in, res_flag_ff;

   always_comb begin
      sum3  = lanes[0].term + lanes[1].term + lanes[2].term;
      gt10  = $signed(lanes[1].term) > $signed(lanes[0].term);
      gt20  = $signed(lanes[2].term) > $signed(lanes[0].term);
      gt21  = $signed(lanes[2].term) > $signed(lanes[1].term);
      max01 = gt10 ? lanes[1].term : lanes[0].term;
      max3  = (gt10 ? gt21 : gt20) ? lanes[2].term : max01;
      vzero = (lanes[0].vec == '0) && (lanes[1].vec == '0) && (lanes[2].vec == '0);

      res_x_in      = '0;
      res_y_in      = '0;
      res_z_in      = '0;
      res_scalar_in = '0;
      res_flag_in   = 1'b0;
      case (op_s3) inside
         OP_ADD, OP_SUB, OP_SCALE, OP_CROSS: begin
            res_x_in = sext(lanes[0].vec);
            res_y_in = sext(lanes[1].vec);
            res_z_in = sext(lanes[2].vec);
         end
         OP_DOT, OP_LENSQ, OP_MANHATTAN: res_scalar_in = sext(sum3);
         OP_CHEBYSHEV:                   res_scalar_in = sext(max3);
         OP_ISZERO, OP_PARALLEL:         res_flag_in   = vzero;
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      res_x_ff      <= res_x_in;
      res_y_ff      <= res_y_in;
      res_z_ff      <= res_z_in;
      res_scalar_ff <= res_scalar_in;
      res_flag_ff   <= res_flag_in;
   end

   assign res_x      = res_x_ff;
   assign res_y      = res_y_ff;
   assign res_z      = res_z_ff;
   assign res_scalar = res_scalar_ff;
   assign res_flag   = res_flag_ff;

endmodule

>>> hdl/iva_checker.sv
// Port-level checks of the integer 3D vector ALU, bound to the top level.
module iva_checker import iva_pkg::*; (
   input logic                   clock,
   input logic                   reset,
   input logic                   start,
   input logic                   busy,
   input logic                   rsp_valid,
   input logic [FIELD_WIDTH-1:0] rsp_res_x,
   input logic [FIELD_WIDTH-1:0] rsp_res_y,
   input logic [FIELD_WIDTH-1:0] rsp_res_z,
   input logic [FIELD_WIDTH-1:0] rsp_res_scalar,
   input logic                   rsp_res_flag
);

   a_transfer_gives_result: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##5 rsp_valid)
      else $error("transfer not answered after five cycles");

   a_result_has_transfer: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, 5))
      else $error("result strobe without a matching transfer");

   a_busy_only_after_reset: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> !busy)
      else $error("busy raised outside reset recovery");

   a_flag_excludes_values: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_res_flag) |->
         (rsp_res_x == '0) && (rsp_res_y == '0) && (rsp_res_z == '0)
         && (rsp_res_scalar == '0))
      else $error("flag result carries nonzero value fields");

   a_vector_excludes_scalar: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && ((rsp_res_x != '0) || (rsp_res_y != '0) || (rsp_res_z != '0))) |->
         (rsp_res_scalar == '0) && !rsp_res_flag)
      else $error("vector result carries scalar or flag");

endmodule

bind integer_vec3_alu iva_checker u_checker (.*);
